@@ sv/fbps_pkg.sv @@
`default_nettype none

package fbps_pkg;

	localparam int BUS_ADDR_W  = 24;
	localparam int WORD_W      = 16;
	localparam int CFG_DATA_W  = 25;
	localparam int CFG_INDEX_W = 3;
	localparam int MAX_RESULTS = 7;
	localparam int RES_IDX_W   = $clog2(MAX_RESULTS);

	// Result operation codes.
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;
	localparam logic [1:0] OP_ERROR  = 2'd3;

	// Input command codes.
	localparam logic CMD_DATA   = 1'b0;
	localparam logic CMD_STATUS = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_START_ADDRESS = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_LENGTH  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SECTOR_LOG2   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_WORDS  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_POLL_LIMIT    = 3'd4;

	// Flash command cycles.
	localparam logic [BUS_ADDR_W-1:0] UNLOCK1_ADDR = 24'h000555;
	localparam logic [WORD_W-1:0]     UNLOCK1_DATA = 16'h00aa;
	localparam logic [BUS_ADDR_W-1:0] UNLOCK2_ADDR = 24'h0002aa;
	localparam logic [WORD_W-1:0]     UNLOCK2_DATA = 16'h0055;
	localparam logic [WORD_W-1:0]     CMD_WRITE_BUFFER = 16'h0025;
	localparam logic [WORD_W-1:0]     CMD_CONFIRM      = 16'h0029;
	localparam int                    STATUS_BIT       = 7;

	typedef struct packed {
		logic              command;
		logic [WORD_W-1:0] word_value;
	} fbps_item_t;

	typedef struct packed {
		logic [1:0]            operation;
		logic [BUS_ADDR_W-1:0] bus_address;
		logic [WORD_W-1:0]     bus_data;
		logic                  timed_out;
		logic                  run_done;
		logic                  last_of_run;
	} fbps_result_t;

	typedef struct packed {
		logic [23:0] start_address;
		logic [24:0] total_length;
		logic [4:0]  sector_words_log2;
		logic [5:0]  buffer_words;
		logic [4:0]  poll_limit;
	} fbps_cfg_t;

	function automatic fbps_result_t make_result(input logic [1:0] op,
			input logic [BUS_ADDR_W-1:0] addr, input logic [WORD_W-1:0] data,
			input logic to, input logic rd);
		fbps_result_t r;
		r.operation   = op;
		r.bus_address = addr;
		r.bus_data    = data;
		r.timed_out   = to;
		r.run_done    = rd;
		r.last_of_run = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

@@ sv/fbps_emit.sv @@
`default_nettype none

module fbps_emit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire fbps_pkg::fbps_result_t load_res [fbps_pkg::MAX_RESULTS],
	output logic                      ready,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output fbps_pkg::fbps_result_t    result
);
	import fbps_pkg::*;

	logic                 valid_q;
	logic [RES_IDX_W-1:0] idx_q;
	fbps_result_t         res_q [MAX_RESULTS];
	fbps_result_t         head;
	logic                 take;

	assign head  = res_q[idx_q];
	assign take  = valid_q && !result_stall;
	// The buffer frees up in the same cycle its final result is taken.
	assign ready = !valid_q || (take && head.last_of_run);

	assign result_valid = valid_q;
	assign result       = head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (ready) begin
			valid_q <= load;
			idx_q   <= '0;
		end else if (take) begin
			idx_q <= idx_q + RES_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			res_q <= load_res;
		end
	end

endmodule

`default_nettype wire

@@ sv/flash_buffer_program_sequencer.sv @@
`default_nettype none

// NOR flash write-buffer programming sequencer. Each accepted item is a data word to
// program or a status word read back; it is turned into one to seven result transactions
// (bus writes, read requests, a chunk-finished marker or an error), and last_of_run marks
// the final one. Results leave one per cycle while result_stall is low. An item has one
// result for a middle data word, a poll reply or an error, five for the first word of a
// longer chunk, three for the last word of a chunk and seven for a one-word chunk; the
// result buffer takes the next item in the cycle the previous item's last result is
// taken. Writing any of the five configuration registers restarts the run from
// start_address; writes are to be made while no transaction is in flight.
module flash_buffer_program_sequencer #(
	parameter int ADDRESS_BITS     = 24,
	parameter int MAX_BUFFER_WORDS = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 item_valid,
	output logic                                      item_stall,
	input  wire fbps_pkg::fbps_item_t                 item,
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output fbps_pkg::fbps_result_t                    result,
	input  wire logic                                 cfg_we,
	input  wire logic [fbps_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [fbps_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import fbps_pkg::*;

	localparam int AB  = ADDRESS_BITS;
	localparam int LGW = $clog2(ADDRESS_BITS + 1);
	localparam int CW  = $clog2(MAX_BUFFER_WORDS + 1);

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_LOAD = 4'b0010,
		PH_POLL = 4'b0100,
		PH_DONE = 4'b1000
	} phase_t;

	function automatic logic [AB-1:0] sector_offset_bits(input logic [4:0] swl);
		logic [LGW-1:0] lg;
		lg = (32'(swl) > AB) ? LGW'(AB) : LGW'(swl);
		return AB'(((AB + 1)'(1) << lg) - (AB + 1)'(1));
	endfunction

	fbps_cfg_t      cfg_q, cfg_n;
	logic           cfg_hit;

	logic [AB-1:0]  next_address_q, next_address_n;
	logic [AB-1:0]  sector_base_q, sector_base_n;
	logic [24:0]    words_remaining_q, words_remaining_n;
	logic [CW-1:0]  chunk_left_q, chunk_left_n;
	logic           last_bit_seven_q, last_bit_seven_n;
	logic [4:0]     poll_count_q, poll_count_n;
	phase_t         phase_q, phase_n;

	logic [AB-1:0]  start_addr;
	logic           accept;
	logic           buf_ready;
	fbps_result_t   res [MAX_RESULTS];

	// Step logic signals.
	logic [AB-1:0]        mask;
	logic [AB:0]          room;
	logic [CW-1:0]        bw, wl, chunk_cur, chunk_after;
	logic [2:0]           pos;
	logic [RES_IDX_W-1:0] last_idx;
	logic [4:0]           lim;
	logic                 match;
	logic                 done;

	assign accept     = item_valid && buf_ready;
	assign item_stall = !buf_ready;

	// Configuration: next register image, and the run restart state derived from it.
	always_comb begin
		cfg_n   = cfg_q;
		cfg_hit = 1'b0;
		if (cfg_we) begin
			unique case (cfg_index)
				REG_START_ADDRESS: begin
					cfg_n.start_address = cfg_wdata[23:0];
					cfg_hit = 1'b1;
				end
				REG_TOTAL_LENGTH: begin
					cfg_n.total_length = cfg_wdata[24:0];
					cfg_hit = 1'b1;
				end
				REG_SECTOR_LOG2: begin
					cfg_n.sector_words_log2 = cfg_wdata[4:0];
					cfg_hit = 1'b1;
				end
				REG_BUFFER_WORDS: begin
					cfg_n.buffer_words = cfg_wdata[5:0];
					cfg_hit = 1'b1;
				end
				REG_POLL_LIMIT: begin
					cfg_n.poll_limit = cfg_wdata[4:0];
					cfg_hit = 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign start_addr = AB'(cfg_n.start_address);

	// One item's worth of work: the result list and the next state.
	always_comb begin
		next_address_n    = next_address_q;
		sector_base_n     = sector_base_q;
		words_remaining_n = words_remaining_q;
		chunk_left_n      = chunk_left_q;
		last_bit_seven_n  = last_bit_seven_q;
		poll_count_n      = poll_count_q;
		phase_n           = phase_q;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			res[i] = make_result(OP_WRITE, '0, '0, 1'b0, 1'b0);
		end

		mask = sector_offset_bits(cfg_q.sector_words_log2);

		if (cfg_q.buffer_words == 6'd0) begin
			bw = CW'(1);
		end else if (32'(cfg_q.buffer_words) > MAX_BUFFER_WORDS) begin
			bw = CW'(MAX_BUFFER_WORDS);
		end else begin
			bw = CW'(cfg_q.buffer_words);
		end
		wl = (words_remaining_q < 25'(bw)) ? CW'(words_remaining_q) : bw;
		// Words left before the sector boundary, never zero.
		room = (AB + 1)'(mask) - (AB + 1)'(next_address_q & mask) + (AB + 1)'(1);
		if (room < (AB + 1)'(wl)) begin
			wl = CW'(room);
		end
		if (wl == '0) begin
			wl = CW'(1);
		end

		lim   = (cfg_q.poll_limit == 5'd0) ? 5'd1 : cfg_q.poll_limit;
		match = item.word_value[STATUS_BIT] == last_bit_seven_q;
		done  = words_remaining_q == 25'd0;

		pos         = 3'd0;
		last_idx    = '0;
		chunk_cur   = chunk_left_q;
		chunk_after = chunk_left_q;

		if (item.command == CMD_DATA &&
				(phase_q == PH_IDLE || phase_q == PH_LOAD)) begin
			if (phase_q == PH_IDLE) begin
				res[0] = make_result(OP_WRITE, UNLOCK1_ADDR, UNLOCK1_DATA, 1'b0, 1'b0);
				res[1] = make_result(OP_WRITE, UNLOCK2_ADDR, UNLOCK2_DATA, 1'b0, 1'b0);
				res[2] = make_result(OP_WRITE, BUS_ADDR_W'(sector_base_q),
					CMD_WRITE_BUFFER, 1'b0, 1'b0);
				res[3] = make_result(OP_WRITE, BUS_ADDR_W'(sector_base_q),
					WORD_W'(wl - CW'(1)), 1'b0, 1'b0);
				pos       = 3'd4;
				chunk_cur = wl;
			end
			res[pos] = make_result(OP_WRITE, BUS_ADDR_W'(next_address_q),
				item.word_value, 1'b0, 1'b0);
			last_idx          = RES_IDX_W'(pos);
			next_address_n    = next_address_q + AB'(1);
			last_bit_seven_n  = item.word_value[STATUS_BIT];
			words_remaining_n = done ? words_remaining_q : words_remaining_q - 25'd1;
			chunk_after       = chunk_cur - CW'(1);
			chunk_left_n      = chunk_after;
			phase_n           = PH_LOAD;
			if (chunk_after == '0) begin
				res[pos + 3'd1] = make_result(OP_WRITE, BUS_ADDR_W'(sector_base_q),
					CMD_CONFIRM, 1'b0, 1'b0);
				res[pos + 3'd2] = make_result(OP_READ, BUS_ADDR_W'(next_address_q),
					'0, 1'b0, 1'b0);
				last_idx     = RES_IDX_W'(pos + 3'd2);
				poll_count_n = 5'd1;
				phase_n      = PH_POLL;
			end
		end else if (item.command == CMD_STATUS && phase_q == PH_POLL) begin
			if (match || poll_count_q >= lim) begin
				res[0] = make_result(OP_FINISH, '0, '0, !match, done);
				sector_base_n = next_address_q & ~mask;
				poll_count_n  = 5'd0;
				phase_n       = done ? PH_DONE : PH_IDLE;
			end else begin
				res[0] = make_result(OP_READ, BUS_ADDR_W'(next_address_q - AB'(1)),
					'0, 1'b0, 1'b0);
				poll_count_n = poll_count_q + 5'd1;
			end
		end else begin
			// A data word outside loading, or a status reply outside polling.
			res[0] = make_result(OP_ERROR, '0, '0, 1'b0, 1'b0);
		end

		res[last_idx].last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_address     <= 24'd0;
			cfg_q.total_length      <= 25'd0;
			cfg_q.sector_words_log2 <= 5'd16;
			cfg_q.buffer_words      <= 6'd32;
			cfg_q.poll_limit        <= 5'd5;
			next_address_q          <= '0;
			sector_base_q           <= '0;
			words_remaining_q       <= '0;
			chunk_left_q            <= '0;
			last_bit_seven_q        <= 1'b0;
			poll_count_q            <= '0;
			phase_q                 <= PH_DONE;
		end else if (cfg_hit) begin
			cfg_q             <= cfg_n;
			next_address_q    <= start_addr;
			sector_base_q     <= start_addr & ~sector_offset_bits(cfg_n.sector_words_log2);
			words_remaining_q <= cfg_n.total_length;
			chunk_left_q      <= '0;
			last_bit_seven_q  <= 1'b0;
			poll_count_q      <= '0;
			phase_q           <= (cfg_n.total_length == 25'd0) ? PH_DONE : PH_IDLE;
		end else if (accept) begin
			next_address_q    <= next_address_n;
			sector_base_q     <= sector_base_n;
			words_remaining_q <= words_remaining_n;
			chunk_left_q      <= chunk_left_n;
			last_bit_seven_q  <= last_bit_seven_n;
			poll_count_q      <= poll_count_n;
			phase_q           <= phase_n;
		end
	end

	fbps_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (item_valid),
		.load_res     (res),
		.ready        (buf_ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

@@ sv/fbps_checker.sv @@
`default_nettype none

module fbps_checker (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   result_valid,
	input wire logic                   result_stall,
	input wire fbps_pkg::fbps_result_t result
);
	import fbps_pkg::*;

	// A stalled result transaction holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// Errors, finish markers and read requests always close an item's results.
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.operation == OP_ERROR |-> result.last_of_run)
		else $error("error result not marked last");

	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.operation == OP_FINISH |-> result.last_of_run)
		else $error("finish result not marked last");

	a_read_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.operation == OP_READ |-> result.last_of_run)
		else $error("read request not marked last");

	// Completion flags only appear on finish markers.
	a_flags_finish: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.operation != OP_FINISH |->
			!result.timed_out && !result.run_done)
		else $error("completion flag on a non-finish result");

endmodule

bind flash_buffer_program_sequencer fbps_checker u_fbps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire

@@ tb/tb_flash_buffer_program_sequencer.sv @@
`default_nettype none

module tb_flash_buffer_program_sequencer;
	import fbps_pkg::*;

	localparam int ADDR_BITS    = 24;
	localparam int MAX_CHUNK    = 32;
	localparam int DRAIN_CYCLES = 10;
	localparam int RANDOM_ITEMS = 210;

	// Indexes past the register list; writes to them must leave the run untouched.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LAST  = 3'd7;

	typedef enum logic [1:0] {PH_IDLE, PH_LOAD, PH_POLL, PH_DONE} prog_phase_e;

	typedef struct {
		logic [23:0] start;
		logic [24:0] total;
		logic [4:0]  sec_log2;
		logic [5:0]  buf_words;
		logic [4:0]  poll_lim;
		logic [23:0] next_addr;
		logic [23:0] sec_base;
		logic [24:0] words_left;
		logic [5:0]  chunk_left;
		logic        last_b7;
		logic [4:0]  polls;
		prog_phase_e phase;
	} seq_state_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         item_valid = 1'b0;
	logic         item_stall;
	fbps_item_t   item = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	fbps_result_t result;
	logic         cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	fbps_item_t   queued_commands[$];
	fbps_result_t expected_bus_ops[$];
	fbps_result_t step_ops[$];
	seq_state_t   model;
	seq_state_t   plan;

	logic took_item = 1'b0;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   mismatches = 0;
	int   items_accepted = 0;
	int   results_checked = 0;
	int   chunks_done = 0;
	int   chunks_timed_out = 0;
	int   errors_seen = 0;
	int   settings_used = 0;
	int   random_sent = 0;

	flash_buffer_program_sequencer #(
		.ADDRESS_BITS(ADDR_BITS),
		.MAX_BUFFER_WORDS(MAX_CHUNK)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned sector_span(input logic [4:0] lg);
		return 64'd1 << ((lg > ADDR_BITS) ? ADDR_BITS : lg);
	endfunction

	function automatic logic [23:0] sector_of(input logic [23:0] addr, input logic [4:0] lg);
		return addr & 24'(~(sector_span(lg) - 64'd1));
	endfunction

	function automatic void queue_op(input logic [1:0] op, input logic [23:0] addr,
			input logic [15:0] data, input logic to, input logic rd);
		fbps_result_t r;
		r.operation   = op;
		r.bus_address = addr;
		r.bus_data    = data;
		r.timed_out   = to;
		r.run_done    = rd;
		r.last_of_run = 1'b0;
		step_ops.push_back(r);
	endfunction

	function automatic seq_state_t restart_run(input seq_state_t s);
		s.next_addr  = s.start;
		s.sec_base   = sector_of(s.start, s.sec_log2);
		s.words_left = s.total;
		s.chunk_left = '0;
		s.last_b7    = 1'b0;
		s.polls      = '0;
		s.phase      = (s.total == 0) ? PH_DONE : PH_IDLE;
		return s;
	endfunction

	function automatic seq_state_t apply_reg(input seq_state_t s,
			input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		case (idx)
			REG_START_ADDRESS: s.start = v[23:0];
			REG_TOTAL_LENGTH:  s.total = v;
			REG_SECTOR_LOG2:   s.sec_log2 = v[4:0];
			REG_BUFFER_WORDS:  s.buf_words = v[5:0];
			REG_POLL_LIMIT:    s.poll_lim = v[4:0];
			default: return s;
		endcase
		return restart_run(s);
	endfunction

	// Computes the bus operations caused by one item into step_ops and returns the new state.
	function automatic seq_state_t step_sequencer(input seq_state_t s, input fbps_item_t it);
		longint unsigned bw;
		longint unsigned room;
		longint unsigned wl;
		longint unsigned lim;
		logic match;
		logic done;
		step_ops.delete();
		if (it.command == CMD_DATA) begin
			if (s.phase == PH_IDLE) begin
				bw = s.buf_words;
				if (bw == 0) bw = 1;
				if (bw > MAX_CHUNK) bw = MAX_CHUNK;
				wl = (s.words_left < bw) ? s.words_left : bw;
				room = s.sec_base + sector_span(s.sec_log2) - s.next_addr;
				if (room < wl) wl = room;
				if (wl == 0) wl = 1;
				queue_op(OP_WRITE, UNLOCK1_ADDR, UNLOCK1_DATA, 1'b0, 1'b0);
				queue_op(OP_WRITE, UNLOCK2_ADDR, UNLOCK2_DATA, 1'b0, 1'b0);
				queue_op(OP_WRITE, s.sec_base, CMD_WRITE_BUFFER, 1'b0, 1'b0);
				queue_op(OP_WRITE, s.sec_base, 16'(wl - 1), 1'b0, 1'b0);
				s.chunk_left = 6'(wl);
				s.phase = PH_LOAD;
			end
			if (s.phase == PH_LOAD) begin
				queue_op(OP_WRITE, s.next_addr, it.word_value, 1'b0, 1'b0);
				s.next_addr = s.next_addr + 24'd1;
				s.last_b7 = it.word_value[STATUS_BIT];
				if (s.words_left != 0) s.words_left = s.words_left - 25'd1;
				s.chunk_left = s.chunk_left - 6'd1;
				if (s.chunk_left == 0) begin
					queue_op(OP_WRITE, s.sec_base, CMD_CONFIRM, 1'b0, 1'b0);
					queue_op(OP_READ, s.next_addr - 24'd1, '0, 1'b0, 1'b0);
					s.polls = 5'd1;
					s.phase = PH_POLL;
				end
			end else begin
				queue_op(OP_ERROR, '0, '0, 1'b0, 1'b0);
			end
		end else if (s.phase == PH_POLL) begin
			lim = (s.poll_lim == 0) ? 1 : s.poll_lim;
			match = (it.word_value[STATUS_BIT] == s.last_b7);
			if (match || s.polls >= lim) begin
				done = (s.words_left == 0);
				queue_op(OP_FINISH, '0, '0, !match, done);
				s.sec_base = sector_of(s.next_addr, s.sec_log2);
				s.polls = '0;
				s.phase = done ? PH_DONE : PH_IDLE;
			end else begin
				queue_op(OP_READ, s.next_addr - 24'd1, '0, 1'b0, 1'b0);
				s.polls = s.polls + 5'd1;
			end
		end else begin
			queue_op(OP_ERROR, '0, '0, 1'b0, 1'b0);
		end
		step_ops[$].last_of_run = 1'b1;
		return s;
	endfunction

	// Driver: a new transaction is offered once the previous one has been taken.
	always @(negedge clk) begin
		if (!item_valid || took_item) begin
			if (queued_commands.size() != 0 && $urandom_range(99) >= idle_pct) begin
				item <= queued_commands.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// Monitor: predicts on each accepted item, then checks each accepted result in order.
	always @(posedge clk) begin
		fbps_result_t want;
		took_item <= arst_n && item_valid && !item_stall;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				model = step_sequencer(model, item);
				foreach (step_ops[i]) expected_bus_ops.push_back(step_ops[i]);
				items_accepted++;
			end
			if (result_valid && !result_stall) begin
				results_checked++;
				if (result.operation == OP_FINISH) begin
					chunks_done++;
					if (result.timed_out) chunks_timed_out++;
				end
				if (result.operation == OP_ERROR) errors_seen++;
				if (expected_bus_ops.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: op %0d addr %h data %h",
							result.operation, result.bus_address, result.bus_data);
				end else begin
					want = expected_bus_ops.pop_front();
					if (result.operation !== want.operation
							|| result.bus_address !== want.bus_address
							|| result.bus_data !== want.bus_data
							|| result.timed_out !== want.timed_out
							|| result.run_done !== want.run_done
							|| result.last_of_run !== want.last_of_run) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch at result %0d:", results_checked);
							$display("  expected op %0d addr %h data %h to %b done %b last %b",
								want.operation, want.bus_address, want.bus_data,
								want.timed_out, want.run_done, want.last_of_run);
							$display("  actual   op %0d addr %h data %h to %b done %b last %b",
								result.operation, result.bus_address, result.bus_data,
								result.timed_out, result.run_done, result.last_of_run);
						end
					end
				end
			end
		end
	end

	task automatic queue_item(input logic cmd, input logic [15:0] w);
		fbps_item_t it;
		it.command = cmd;
		it.word_value = w;
		queued_commands.push_back(it);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		model = apply_reg(model, idx, v);
	endtask

	task automatic configure(input logic [24:0] start_v, input logic [24:0] total_v,
			input logic [4:0] lg_v, input logic [5:0] bw_v, input logic [4:0] pl_v);
		write_reg(REG_START_ADDRESS, start_v);
		write_reg(REG_TOTAL_LENGTH, total_v);
		write_reg(REG_SECTOR_LOG2, 25'(lg_v));
		write_reg(REG_BUFFER_WORDS, 25'(bw_v));
		write_reg(REG_POLL_LIMIT, 25'(pl_v));
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (queued_commands.size() != 0 || item_valid || expected_bus_ops.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Mostly well-formed traffic for the current phase of the run, with some
	// out-of-phase transactions mixed in; stops after n items, or two items into the finished run.
	task automatic plan_batch(input int n);
		fbps_item_t it;
		int tail;
		plan = model;
		tail = 0;
		for (int k = 0; k < n && tail < 2; k++) begin
			it.word_value = 16'($urandom);
			case (plan.phase)
				PH_POLL: it.command = ($urandom_range(99) < 90) ? CMD_STATUS : CMD_DATA;
				PH_DONE: begin
					it.command = 1'($urandom_range(1));
					tail++;
				end
				default: it.command = ($urandom_range(99) < 92) ? CMD_DATA : CMD_STATUS;
			endcase
			plan = step_sequencer(plan, it);
			queued_commands.push_back(it);
			random_sent++;
		end
	endtask

	initial begin
		logic [4:0]      lg;
		longint unsigned span;
		logic [24:0]     start_v;
		logic [24:0]     total_v;
		logic [5:0]      bw_v;
		logic [4:0]      pl_v;
		int              phase_no;

		model.start = '0;
		model.total = '0;
		model.sec_log2 = 5'd16;
		model.buf_words = 6'd32;
		model.poll_lim = 5'd5;
		model = restart_run(model);
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Out of reset the run is empty, so everything is a protocol error.
		stall_pct = 38;
		idle_pct = 38;
		queue_item(CMD_DATA, 16'h5a5a);
		queue_item(CMD_STATUS, 16'h0080);
		wait_drained();

		// Run that starts three words below a sector boundary with two-word chunks.
		configure(25'h00fffd, 25'd5, 5'd16, 6'd2, 5'd2);
		queue_item(CMD_STATUS, 16'h1234);
		queue_item(CMD_DATA, 16'h0000);
		queue_item(CMD_DATA, 16'hffff);
		queue_item(CMD_DATA, 16'h4321);
		queue_item(CMD_STATUS, 16'h0000);
		queue_item(CMD_STATUS, 16'h007f);
		wait_drained();
		write_reg(REG_UNUSED_FIRST, 25'h1ffffff);
		write_reg(REG_UNUSED_LAST, 25'h0000000);
		@(negedge clk);
		cfg_we <= 1'b0;
		queue_item(CMD_DATA, 16'h0080);
		queue_item(CMD_STATUS, 16'h0080);
		queue_item(CMD_DATA, 16'h1234);
		queue_item(CMD_DATA, 16'hff7f);
		queue_item(CMD_STATUS, 16'hffff);
		queue_item(CMD_STATUS, 16'hff00);
		queue_item(CMD_DATA, 16'haaaa);
		queue_item(CMD_STATUS, 16'h5555);
		wait_drained();

		// Top of the address space with clipped sector size, chunk and poll limits.
		configure(25'h1ffffff, 25'd3, 5'd31, 6'd0, 5'd0);
		queue_item(CMD_DATA, 16'h8000);
		queue_item(CMD_STATUS, 16'h0080);
		queue_item(CMD_DATA, 16'h00ff);
		queue_item(CMD_STATUS, 16'h00ff);
		queue_item(CMD_DATA, 16'h7fff);
		queue_item(CMD_STATUS, 16'h0000);
		wait_drained();

		phase_no = 0;
		while (random_sent < RANDOM_ITEMS) begin
			case (phase_no % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 64; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 64; end
				default: begin idle_pct = 38; stall_pct = 38; end
			endcase
			lg = ($urandom_range(9) < 8) ? 5'($urandom_range(12, 20)) : 5'($urandom);
			span = sector_span(lg);
			start_v = 25'($urandom);
			if ($urandom_range(1))
				start_v[23:0] = (start_v[23:0] | 24'(span - 1)) - 24'($urandom_range(0, 40));
			case ($urandom_range(9))
				0: total_v = '0;
				1: total_v = $urandom_range(1) ? 25'h1000000 : 25'h1ffffff;
				default: total_v = 25'($urandom_range(1, 80));
			endcase
			case ($urandom_range(9))
				0: bw_v = '0;
				1: bw_v = 6'($urandom_range(33, 63));
				2: bw_v = 6'd32;
				3: bw_v = 6'd1;
				default: bw_v = 6'($urandom_range(2, 31));
			endcase
			case ($urandom_range(9))
				0: pl_v = '0;
				1: pl_v = 5'($urandom_range(17, 31));
				2: pl_v = 5'd16;
				default: pl_v = 5'($urandom_range(1, 4));
			endcase
			configure(start_v, total_v, lg, bw_v, pl_v);
			plan_batch($urandom_range(20, 45));
			wait_drained();
			// Once, hold the sender back until every pending result is in, then resume.
			if (phase_no == 2) begin
				plan_batch(20);
				wait_drained();
			end
			phase_no++;
		end

		$display("checked %0d results from %0d items under %0d register settings",
			results_checked, items_accepted, settings_used);
		$display("%0d chunks finished, %0d of them by poll timeout; %0d protocol errors",
			chunks_done, chunks_timed_out, errors_seen);
		if (mismatches == 0 && expected_bus_ops.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
sv/fbps_pkg.sv
sv/fbps_emit.sv
sv/flash_buffer_program_sequencer.sv
sv/fbps_checker.sv
tb/tb_flash_buffer_program_sequencer.sv
